// ===== design/hmmf_pkg.sv =====
// ----------------------------------------------------------------------------
// hmmf_pkg: shared types and constants of the HMM forward filter step
// Control word layout, microprogram, register indexes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hmmf_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_TRUST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_UNTRUST = 2'd2;

    // Reset values
    localparam logic [63:0] TRANS_RESET   = 64'h199A_6666_199A_6666;
    localparam logic [15:0] BELIEF_T_INIT = 16'd26214;
    localparam logic [15:0] BELIEF_U_INIT = 16'd6554;

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;

    // Datapath widths
    localparam int MUL_A_W = 18;                 // widest multiplicand (pt)
    localparam int PROD_W  = MUL_A_W + 16;
    localparam int ACC_W   = PROD_W - 15;        // product after >> 15
    localparam int SUM_W   = ACC_W + 1;

    // Microprogram counter
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;
    localparam logic [PC_W-1:0] PC_DIRECT = 5'd6;
    localparam logic [PC_W-1:0] PC_WEIGHT = 5'd7;
    localparam logic [PC_W-1:0] PC_KEEP   = 5'd16;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_STEP,
        OP_GOTO,
        OP_LOAD_DIRECT,
        OP_ZCHK,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_COMMIT,
        OP_KEEP
    } op_t;

    typedef enum logic [1:0] {
        MA_BT,
        MA_BU,
        MA_PT,
        MA_PU
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_TT,
        MB_TU,
        MB_UT,
        MB_UU,
        MB_ET,
        MB_EU
    } mul_b_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_PT_LD,
        WB_PT_ADD,
        WB_PU_LD,
        WB_PU_ADD,
        WB_AT,
        WB_AU
    } wb_t;

    typedef enum logic {
        DS_TRUSTED,
        DS_UNTRUSTED
    } div_sel_t;

    typedef struct packed {
        op_t             op;
        mul_a_t          ma;
        mul_b_t          mb;
        wb_t             wb;
        div_sel_t        dsel;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Microprogram ROM. The multiplier result is registered, so each
    // write-back field refers to the product issued by the previous step.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_IDLE, ma: MA_BT, mb: MB_TT, wb: WB_NONE,
              dsel: DS_TRUSTED, target: PC_IDLE};
        unique case (pc)
            5'd0:  begin w.op = OP_IDLE; w.target = PC_DIRECT; end
            // propagate through the transition matrix
            5'd1:  begin w.op = OP_STEP; w.ma = MA_BT; w.mb = MB_TT; end
            5'd2:  begin w.op = OP_STEP; w.ma = MA_BU; w.mb = MB_UT; w.wb = WB_PT_LD; end
            5'd3:  begin w.op = OP_STEP; w.ma = MA_BT; w.mb = MB_TU; w.wb = WB_PT_ADD; end
            5'd4:  begin w.op = OP_STEP; w.ma = MA_BU; w.mb = MB_UU; w.wb = WB_PU_LD; end
            5'd5:  begin w.op = OP_GOTO; w.wb = WB_PU_ADD; w.target = PC_WEIGHT; end
            // first item: belief used as is
            5'd6:  w.op = OP_LOAD_DIRECT;
            // emission weighting
            5'd7:  begin w.op = OP_STEP; w.ma = MA_PT; w.mb = MB_ET; end
            5'd8:  begin w.op = OP_STEP; w.ma = MA_PU; w.mb = MB_EU; w.wb = WB_AT; end
            5'd9:  begin w.op = OP_STEP; w.wb = WB_AU; end
            5'd10: begin w.op = OP_ZCHK; w.target = PC_KEEP; end
            // normalization
            5'd11: begin w.op = OP_DIV_START; w.dsel = DS_TRUSTED; end
            5'd12: begin w.op = OP_DIV_WAIT;  w.dsel = DS_TRUSTED; end
            5'd13: begin w.op = OP_DIV_START; w.dsel = DS_UNTRUSTED; end
            5'd14: begin w.op = OP_DIV_WAIT;  w.dsel = DS_UNTRUSTED; end
            5'd15: w.op = OP_COMMIT;
            5'd16: w.op = OP_KEEP;
            default: w.op = OP_IDLE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/hmmf_div.sv =====
// ----------------------------------------------------------------------------
// hmmf_div: radix-2 restoring divider for belief normalization
// Computes floor((num << 15) / den) for num <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmf_div
    import hmmf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [ACC_W-1:0]   num,
    input  wire logic [SUM_W-1:0]   den,
    output div_stat_t               stat,
    output logic [15:0]             quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [15:0]          dvd_reg, dvd_next;
    logic [15:0]          quot_reg, quot_next;

    logic [SUM_W:0]       rem_sh;
    logic [SUM_W:0]       diff;
    logic                 ge;

    // trial subtract
    assign rem_sh = {rem_reg, dvd_reg[15]};
    assign diff   = rem_sh - {1'b0, den};
    assign ge     = (rem_sh >= {1'b0, den});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        if (start)
        begin
            // num <= den, so num >> 1 < den: quotient fits 16 bits
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {2'b00, num[ACC_W-1:1]};
            dvd_next  = {num[0], 15'd0};
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            dvd_next  = {dvd_reg[14:0], 1'b0};
            quot_next = {quot_reg[14:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

// ===== design/hmm_forward_filter_step.sv =====
// ----------------------------------------------------------------------------
// hmm_forward_filter_step: normalized two-state HMM forward step, Q1.15
// Microcoded sequencer over one shared multiplier and a radix-2 divider.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   in       | in_valid, in_ready, observation,         | input item
//            | first_item                               |
//   out      | out_valid, out_ready, new_trusted,       | result item
//            | new_untrusted, zero_sum                  |
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
// An item with first_item set skips the propagation steps, and a zero sum
// skips normalization; otherwise two passes through the shared divider (start
// step, one step per quotient bit, done) dominate an item's run time.
// One item is in flight at a time; the next is taken once the result sits
// in the output register. A stalled output holds the sequencer at its final
// step. Reset loads the default transition matrix and belief; cfg is
// always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hmm_forward_filter_step
    import hmmf_pkg::*;
#(
    parameter int NUM_OBS = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           observation,
    input  wire logic                 first_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [15:0]               new_trusted,
    output logic [15:0]               new_untrusted,
    output logic                      zero_sum,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    localparam logic [2:0] ObsLimit = 3'(NUM_OBS);

    // control
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        belief_t_reg, belief_t_next;
    logic [15:0]        belief_u_reg, belief_u_next;
    logic [63:0]        trans_reg, trans_next;
    logic [63:0]        emit_t_reg, emit_t_next;
    logic [63:0]        emit_u_reg, emit_u_next;

    // datapath
    logic [15:0]        et_reg, et_next;
    logic [15:0]        eu_reg, eu_next;
    logic [MUL_A_W-1:0] pt_reg, pt_next;
    logic [MUL_A_W-1:0] pu_reg, pu_next;
    logic [ACC_W-1:0]   at_reg, at_next;
    logic [ACC_W-1:0]   au_reg, au_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [15:0]        qt_reg, qt_next;
    logic [15:0]        qu_reg, qu_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [15:0]        out_t_reg, out_t_next;
    logic [15:0]        out_u_reg, out_u_next;
    logic               out_z_reg, out_z_next;

    uword_t             uw;
    logic               in_accept;
    logic               out_free;
    logic               obs_ok;
    logic [MUL_A_W-1:0] mul_a;
    logic [15:0]        mul_b;
    logic [ACC_W-1:0]   wb_val;
    logic [SUM_W-1:0]   sum_w;
    logic               div_start;
    logic [ACC_W-1:0]   div_num;
    div_stat_t          div_stat;
    logic [15:0]        div_quot;

    assign uw        = ucode(pc_reg);
    assign in_ready  = (uw.op == OP_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign obs_ok    = ({1'b0, observation} < ObsLimit);

    // multiplier operand select
    always_comb
    begin
        unique case (uw.ma)
            MA_BT:   mul_a = {2'b00, belief_t_reg};
            MA_BU:   mul_a = {2'b00, belief_u_reg};
            MA_PT:   mul_a = pt_reg;
            MA_PU:   mul_a = pu_reg;
            default: mul_a = '0;
        endcase
        unique case (uw.mb)
            MB_TT:   mul_b = trans_reg[15:0];
            MB_TU:   mul_b = trans_reg[31:16];
            MB_UT:   mul_b = trans_reg[47:32];
            MB_UU:   mul_b = trans_reg[63:48];
            MB_ET:   mul_b = et_reg;
            MB_EU:   mul_b = eu_reg;
            default: mul_b = '0;
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign wb_val    = prod_reg[PROD_W-1:15];
    assign sum_w     = {1'b0, at_reg} + {1'b0, au_reg};
    assign div_start = (uw.op == OP_DIV_START);
    assign div_num   = (uw.dsel == DS_TRUSTED) ? at_reg : au_reg;

    hmmf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sum_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // sequencer and datapath next state
    always_comb
    begin
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        belief_t_next  = belief_t_reg;
        belief_u_next  = belief_u_reg;
        trans_next     = trans_reg;
        emit_t_next    = emit_t_reg;
        emit_u_next    = emit_u_reg;
        et_next        = et_reg;
        eu_next        = eu_reg;
        pt_next        = pt_reg;
        pu_next        = pu_reg;
        at_next        = at_reg;
        au_next        = au_reg;
        sum_next       = sum_reg;
        qt_next        = qt_reg;
        qu_next        = qu_reg;
        out_t_next     = out_t_reg;
        out_u_next     = out_u_reg;
        out_z_next     = out_z_reg;

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TRANS:        trans_next  = cfg_data;
                CFG_EMIT_TRUST:   emit_t_next = cfg_data;
                CFG_EMIT_UNTRUST: emit_u_next = cfg_data;
                default:          ;
            endcase
        end

        // product write-back
        case (uw.wb)
            WB_PT_LD:  pt_next = wb_val[MUL_A_W-1:0];
            WB_PT_ADD: pt_next = pt_reg + wb_val[MUL_A_W-1:0];
            WB_PU_LD:  pu_next = wb_val[MUL_A_W-1:0];
            WB_PU_ADD: pu_next = pu_reg + wb_val[MUL_A_W-1:0];
            WB_AT:     at_next = wb_val;
            WB_AU:     au_next = wb_val;
            default:   ;
        endcase

        unique case (uw.op)
            OP_IDLE:
            begin
                if (in_accept)
                begin
                    // unused observation lanes read zero emission
                    et_next = obs_ok ? emit_t_reg[{observation, 4'b0000} +: 16] : 16'd0;
                    eu_next = obs_ok ? emit_u_reg[{observation, 4'b0000} +: 16] : 16'd0;
                    pc_next = first_item ? uw.target : pc_reg + 1'b1;
                end
            end
            OP_STEP, OP_DIV_START:
                pc_next = pc_reg + 1'b1;
            OP_GOTO:
                pc_next = uw.target;
            OP_LOAD_DIRECT:
            begin
                pt_next = {2'b00, belief_t_reg};
                pu_next = {2'b00, belief_u_reg};
                pc_next = pc_reg + 1'b1;
            end
            OP_ZCHK:
            begin
                sum_next = sum_w;
                pc_next  = (sum_w == '0) ? uw.target : pc_reg + 1'b1;
            end
            OP_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (uw.dsel == DS_TRUSTED)
                        qt_next = div_quot;
                    else
                        qu_next = div_quot;
                    pc_next = pc_reg + 1'b1;
                end
            end
            OP_COMMIT:
            begin
                if (out_free)
                begin
                    belief_t_next  = qt_reg;
                    belief_u_next  = qu_reg;
                    out_t_next     = qt_reg;
                    out_u_next     = qu_reg;
                    out_z_next     = 1'b0;
                    out_valid_next = 1'b1;
                    pc_next        = PC_IDLE;
                end
            end
            OP_KEEP:
            begin
                // zero sum: belief kept and reported
                if (out_free)
                begin
                    out_t_next     = belief_t_reg;
                    out_u_next     = belief_u_reg;
                    out_z_next     = 1'b1;
                    out_valid_next = 1'b1;
                    pc_next        = PC_IDLE;
                end
            end
            default:
                pc_next = PC_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            out_valid_reg <= 1'b0;
            belief_t_reg  <= BELIEF_T_INIT;
            belief_u_reg  <= BELIEF_U_INIT;
            trans_reg     <= TRANS_RESET;
            emit_t_reg    <= '0;
            emit_u_reg    <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            belief_t_reg  <= belief_t_next;
            belief_u_reg  <= belief_u_next;
            trans_reg     <= trans_next;
            emit_t_reg    <= emit_t_next;
            emit_u_reg    <= emit_u_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        et_reg    <= et_next;
        eu_reg    <= eu_next;
        pt_reg    <= pt_next;
        pu_reg    <= pu_next;
        at_reg    <= at_next;
        au_reg    <= au_next;
        sum_reg   <= sum_next;
        qt_reg    <= qt_next;
        qu_reg    <= qu_next;
        prod_reg  <= prod_next;
        out_t_reg <= out_t_next;
        out_u_reg <= out_u_next;
        out_z_reg <= out_z_next;
    end

    assign out_valid     = out_valid_reg;
    assign new_trusted   = out_t_reg;
    assign new_untrusted = out_u_reg;
    assign zero_sum      = out_z_reg;

`ifndef NO_ASSERTIONS
    // divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (uw.op == OP_DIV_WAIT))
        else $error("divider done outside wait step");

    // no new item while the divider is running
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    // a zero-sum result reports the belief that was kept
    a_zero_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_z_reg) |->
            (out_t_reg == belief_t_reg && out_u_reg == belief_u_reg))
        else $error("zero-sum result differs from kept belief");

    // normalized beliefs never sum past one
    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_z_reg) |->
            ({1'b0, out_t_reg} + {1'b0, out_u_reg} <= 17'd32768))
        else $error("normalized belief exceeds one");
`endif

endmodule

`default_nettype wire

// ===== verif/hmmf_checker.sv =====
// ----------------------------------------------------------------------------
// hmmf_checker: result predictor and scoreboard for hmm_forward_filter_step
// Watches the cfg, in and out channels. Keeps its own copy of the registers
// and of the two-entry belief, works out the normalized forward step for
// each accepted input item, and compares each result item field by field.
// ----------------------------------------------------------------------------
module hmmf_checker
    import hmmf_pkg::*;
#(
    parameter int NUM_OBS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           observation,
    input  logic                 first_item,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [15:0]          new_trusted,
    input  logic [15:0]          new_untrusted,
    input  logic                 zero_sum,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output int                   mismatch_count,
    output int                   results_owed
);

    typedef struct packed {
        logic [15:0] trusted;
        logic [15:0] untrusted;
        logic        zero;
    } belief_res_t;

    // register and belief copies
    logic [63:0] trans_m;
    logic [63:0] emit_t;
    logic [63:0] emit_u;
    logic [15:0] bel_t;
    logic [15:0] bel_u;

    belief_res_t belief_expect_q[$];
    belief_res_t got_res;
    belief_res_t want_res;

    initial mismatch_count = 0;

    function automatic logic [63:0] lane_of(input logic [63:0] r, input int k);
        return 64'(r[16*k +: 16]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one normalized forward step; updates the belief copy, queues the result
    task automatic forward_predict(input logic [1:0] obs, input logic first);
        logic [63:0] et;
        logic [63:0] eu;
        logic [63:0] pt;
        logic [63:0] pu;
        logic [63:0] at;
        logic [63:0] au;
        logic [63:0] sum;
        belief_res_t res;
        et = '0;
        eu = '0;
        // lanes at or past NUM_OBS read as zero emission
        if (int'(obs) < NUM_OBS) begin
            et = lane_of(emit_t, int'(obs));
            eu = lane_of(emit_u, int'(obs));
        end
        if (first) begin
            pt = 64'(bel_t);
            pu = 64'(bel_u);
        end
        else begin
            pt = ((64'(bel_t) * lane_of(trans_m, 0)) >> 15) +
                 ((64'(bel_u) * lane_of(trans_m, 2)) >> 15);
            pu = ((64'(bel_t) * lane_of(trans_m, 1)) >> 15) +
                 ((64'(bel_u) * lane_of(trans_m, 3)) >> 15);
        end
        at  = (pt * et) >> 15;
        au  = (pu * eu) >> 15;
        sum = at + au;
        if (sum == 0) begin
            // belief kept, flagged
            res = '{trusted: bel_t, untrusted: bel_u, zero: 1'b1};
        end
        else begin
            bel_t = 16'((at << 15) / sum);
            bel_u = 16'((au << 15) / sum);
            res = '{trusted: bel_t, untrusted: bel_u, zero: 1'b0};
        end
        belief_expect_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            trans_m      = TRANS_RESET;
            emit_t       = '0;
            emit_u       = '0;
            bel_t        = BELIEF_T_INIT;
            bel_u        = BELIEF_U_INIT;
            belief_expect_q.delete();
            results_owed <= 0;
        end
        else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TRANS:        trans_m = cfg_data;
                    CFG_EMIT_TRUST:   emit_t  = cfg_data;
                    CFG_EMIT_UNTRUST: emit_u  = cfg_data;
                    default: ;
                endcase
            end

            // result items, checked before this edge's input is queued
            if (out_valid && out_ready) begin
                got_res = '{trusted: new_trusted, untrusted: new_untrusted,
                            zero: zero_sum};
                if (belief_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d/%0d zero_sum=%0b",
                                              new_trusted, new_untrusted, zero_sum));
                end
                else begin
                    want_res = belief_expect_q.pop_front();
                    if (got_res.trusted !== want_res.trusted)
                        report_mismatch($sformatf("new_trusted got %0d exp %0d",
                                                  got_res.trusted, want_res.trusted));
                    if (got_res.untrusted !== want_res.untrusted)
                        report_mismatch($sformatf("new_untrusted got %0d exp %0d",
                                                  got_res.untrusted, want_res.untrusted));
                    if (got_res.zero !== want_res.zero)
                        report_mismatch($sformatf("zero_sum got %0b exp %0b",
                                                  got_res.zero, want_res.zero));
                end
            end

            // input items
            if (in_valid && in_ready)
                forward_predict(observation, first_item);

            results_owed <= belief_expect_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for hmm_forward_filter_step
// Drives register writes and observation items with random gaps and output
// stalls. A short directed part covers zero emissions, zero transitions,
// saturated lanes and belief pinned at one state; random register settings
// with random item runs follow. The checker does all prediction and checking.
// ----------------------------------------------------------------------------
module tb;
    import hmmf_pkg::*;

    localparam int NUM_OBS      = 4;
    localparam int RANDOM_ITEMS = 1030;
    localparam int DRAIN_CYCLES = 64;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           observation = '0;
    logic                 first_item = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [15:0]          new_trusted;
    logic [15:0]          new_untrusted;
    logic                 zero_sum;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    int mismatch_count;
    int results_owed;
    bit full_rate = 1'b0;
    int stall_left = 0;
    int stall_pick;
    int random_sent;
    int run_len;

    always #4 clk = ~clk;

    hmm_forward_filter_step #(
        .NUM_OBS(NUM_OBS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .observation(observation),
        .first_item(first_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .new_trusted(new_trusted),
        .new_untrusted(new_untrusted),
        .zero_sum(zero_sum),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    hmmf_checker #(
        .NUM_OBS(NUM_OBS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .observation(observation),
        .first_item(first_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .new_trusted(new_trusted),
        .new_untrusted(new_untrusted),
        .zero_sum(zero_sum),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count),
        .results_owed(results_owed)
    );

    // output back-pressure: mostly ready, short stalls, rare long ones
    always @(posedge clk) begin
        if (full_rate) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60) begin
                out_ready  <= 1'b1;
                stall_left <= $urandom_range(1, 12);
            end
            else if (stall_pick < 95) begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(1, 3);
            end
            else begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(20, 80);
            end
        end
        else begin
            stall_left <= stall_left - 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_rate || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    // one Q1.15 lane, biased toward the edges
    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'($urandom_range(1, 16));
            4:       return 16'($urandom_range(16'h8001, 16'hFFFE));
            default: return 16'($urandom_range(0, 16'h8000));
        endcase
    endfunction

    function automatic logic [63:0] rand_reg();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return 64'h0;
        else if (mode == 1)
            return '1;
        else
            return {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
    endfunction

    task automatic send_item(input logic [1:0] obs, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        observation <= obs;
        first_item  <= first;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    // all three registers, valid held across the writes
    task automatic program_regs(input logic [63:0] tm, input logic [63:0] et,
                                input logic [63:0] eu);
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            case (i)
                0:       begin cfg_index <= CFG_TRANS;        cfg_data <= tm; end
                1:       begin cfg_index <= CFG_EMIT_TRUST;   cfg_data <= et; end
                default: begin cfg_index <= CFG_EMIT_UNTRUST; cfg_data <= eu; end
            endcase
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: emissions all zero, every item keeps the belief
        send_item(2'd0, 1'b1);
        send_item(2'd3, 1'b0);

        // typical matrix; observation 3 has zero emission in both states
        settle();
        program_regs(TRANS_RESET, 64'h0000_1000_4000_7333, 64'h0000_6000_2000_0CCD);
        send_item(2'd0, 1'b1);
        send_item(2'd1, 1'b0);
        send_item(2'd2, 1'b0);
        send_item(2'd3, 1'b0);
        send_item(2'd0, 1'b0);
        send_item(2'd2, 1'b1);

        // every lane saturated
        settle();
        program_regs('1, '1, '1);
        send_item(2'd0, 1'b0);
        send_item(2'd3, 1'b1);
        send_item(2'd1, 1'b0);

        // zero transitions: propagation yields a zero sum, so the belief is kept
        settle();
        program_regs(64'h0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        send_item(2'd1, 1'b0);
        send_item(2'd2, 1'b1);

        // identity matrix; pin the belief to trusted, then starve it
        settle();
        program_regs(64'h8000_0000_0000_8000, 64'h0000_0000_0000_8000,
                     64'h0000_0000_FFFF_0000);
        send_item(2'd0, 1'b1);
        send_item(2'd1, 1'b1);
        send_item(2'd1, 1'b0);
        send_item(2'd0, 1'b0);

        // random register settings, each followed by a run of items
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            settle();
            program_regs(rand_reg(), rand_reg(), rand_reg());
            full_rate <= ($urandom_range(0, 4) == 0);
            run_len = $urandom_range(20, 80);
            repeat (run_len) begin
                send_item(2'($urandom_range(0, 3)), ($urandom_range(0, 99) < 15));
                random_sent++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard
    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/hmmf_pkg.sv
design/hmmf_div.sv
design/hmm_forward_filter_step.sv
verif/hmmf_checker.sv
verif/tb.sv
